@@ rtl/bhc_pkg.sv @@
// Package: shared constants and types of the block header compressor.
`timescale 1ns / 1ps
package bhc_pkg;

   localparam int BHC_HISTORY_DEPTH = 7;   // default history length
   localparam int BHC_POS_W         = 5;   // holds positions 1..31 of the longest history
   localparam int BHC_OFFSET_W      = 3;   // coded version position
   localparam int BHC_WORD_W        = 32;
   localparam int BHC_TIME_OFF_W    = 16;

   // Search result handed from cell to cell toward the back of the list.
   typedef struct packed {
      logic                 found;
      logic [BHC_POS_W-1:0] pos;
   } link_type;

   // One compressed header as held in the output registers.
   typedef struct packed {
      logic [BHC_OFFSET_W-1:0]          ver_position;
      logic                             prev_hash_compressed;
      logic                             time_compressed;
      logic signed [BHC_TIME_OFF_W-1:0] time_delta;
      logic                             bits_compressed;
   } rsp_type;

endpackage

@@ rtl/bhc_if.sv @@
// Interfaces: header input channel and compressed result channel.
`timescale 1ns / 1ps
interface bhc_req_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] version;
   logic [31:0] header_time;
   logic [31:0] target_bits;
   logic        has_previous;
   logic [31:0] prev_time;
   logic [31:0] prev_bits;

   modport source (output valid, version, header_time, target_bits, has_previous,
                   prev_time, prev_bits, input ready);
   modport sink   (input valid, version, header_time, target_bits, has_previous,
                   prev_time, prev_bits, output ready);
endinterface

interface bhc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  ver_position;
   logic        prev_hash_compressed;
   logic        time_compressed;
   logic signed [15:0] time_delta;
   logic        bits_compressed;

   modport source (output valid, ver_position, prev_hash_compressed, time_compressed,
                   time_delta, bits_compressed, input ready);
   modport sink   (input valid, ver_position, prev_hash_compressed, time_compressed,
                   time_delta, bits_compressed, output ready);
endinterface

@@ rtl/bhc_cell.sv @@
// One history cell: holds an entry, compares it, shifts from its front neighbor.
`timescale 1ns / 1ps
module bhc_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic                               has_previous,
   input  logic [bhc_pkg::BHC_WORD_W-1:0]     version,
   input  logic [bhc_pkg::BHC_WORD_W-1:0]     front_entry,
   input  logic                               front_valid,
   input  bhc_pkg::link_type                  link_in,
   output bhc_pkg::link_type                  link_out,
   output logic [bhc_pkg::BHC_WORD_W-1:0]     entry,
   output logic                               valid
);

   localparam logic [bhc_pkg::BHC_POS_W-1:0] MyPos = bhc_pkg::BHC_POS_W'(CELL_INDEX + 1);

   logic [bhc_pkg::BHC_WORD_W-1:0] entry_ff, entry_in;
   logic                           valid_ff, valid_in;
   logic                           match;
   logic                           shift;

   assign match = valid_ff && (entry_ff == version);

   always_comb begin
      link_out = link_in;
      if (!link_in.found && match) begin
         link_out.found = 1'b1;
         link_out.pos   = MyPos;
      end
   end

   // Cells up to and including the hit move back one; all move on a miss or a plain push.
   assign shift = accept && (!has_previous || !link_in.found);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (shift) begin
         entry_in = front_entry;
         valid_in = front_valid;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

@@ rtl/bhc_out_buf.sv @@
// Two-entry output buffer: result register plus skid register.
`timescale 1ns / 1ps
module bhc_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bhc_pkg::rsp_type push_data,
   output logic             room,
   output logic             out_valid,
   input  logic             out_ready,
   output bhc_pkg::rsp_type out_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   bhc_pkg::rsp_type out_data_ff, out_data_in;
   bhc_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             out_free;

   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign room      = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while result register empty");

endmodule

@@ rtl/block_header_compressor_top.sv @@
// Top level: block header compressor with move-to-front version history.
// An accepted header's result reaches rsp_chan from the result register, via skid on a stall.
// Throughput: one header per cycle while ready is high; history updates in the transfer cycle.
// Rate is set by the cell chain: compare in every cell, first hit ripples back, one shift step.
// Output side holds a result register and a skid register, so req_chan takes one more
// transfer while rsp_chan stalls. Reset (synchronous) empties the history and both output
// registers; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
module block_header_compressor_top #(
   parameter int HISTORY_DEPTH = bhc_pkg::BHC_HISTORY_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   bhc_req_if.sink     req_chan,
   bhc_rsp_if.source   rsp_chan
);

   localparam int WordW = bhc_pkg::BHC_WORD_W;

   // Chain signals; index 0 is the front (most recent) of the list.
   logic [WordW-1:0]        entry [HISTORY_DEPTH+1];
   logic [HISTORY_DEPTH:0]  valid_chain;
   bhc_pkg::link_type       link [HISTORY_DEPTH+1];
   logic [HISTORY_DEPTH-1:0] valid_vec;

   logic             accept;
   logic             room;
   bhc_pkg::rsp_type result;
   bhc_pkg::rsp_type out_data;
   logic [WordW:0]   time_span;   // 33-bit signed difference
   logic             time_fits;

   assign accept         = req_chan.valid && room;
   assign req_chan.ready = room;

   // Front of the chain: the new version enters cell 0, no hit yet.
   assign entry[0]       = req_chan.version;
   assign valid_chain[0] = 1'b1;
   assign link[0]        = '0;

   for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
      bhc_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .accept       (accept),
         .has_previous (req_chan.has_previous),
         .version      (req_chan.version),
         .front_entry  (entry[g]),
         .front_valid  (valid_chain[g]),
         .link_in      (link[g]),
         .link_out     (link[g+1]),
         .entry        (entry[g+1]),
         .valid        (valid_chain[g+1])
      );
   end

   assign valid_vec = valid_chain[HISTORY_DEPTH:1];

   // Time offset: signed difference, kept only if it fits 16 bits.
   assign time_span = {1'b0, req_chan.header_time} - {1'b0, req_chan.prev_time};
   assign time_fits = (time_span[WordW:bhc_pkg::BHC_TIME_OFF_W-1] == '0) ||
                      (time_span[WordW:bhc_pkg::BHC_TIME_OFF_W-1] == '1);

   always_comb begin
      result = '0;
      if (req_chan.has_previous) begin
         result.ver_position         = link[HISTORY_DEPTH].found ?
            link[HISTORY_DEPTH].pos[bhc_pkg::BHC_OFFSET_W-1:0] : '0;
         result.prev_hash_compressed = 1'b1;
         result.time_compressed      = time_fits;
         result.time_delta           = time_fits ?
            time_span[bhc_pkg::BHC_TIME_OFF_W-1:0] : '0;
         result.bits_compressed      = (req_chan.target_bits == req_chan.prev_bits);
      end
   end

   bhc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .room      (room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.ver_position         = out_data.ver_position;
   assign rsp_chan.prev_hash_compressed = out_data.prev_hash_compressed;
   assign rsp_chan.time_compressed      = out_data.time_compressed;
   assign rsp_chan.time_delta           = out_data.time_delta;
   assign rsp_chan.bits_compressed      = out_data.bits_compressed;

   // History fills from the front: no hole ahead of a valid entry.
   a_valid_packed : assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("history valid bits not packed to the front");

   // Any transfer leaves its version at the front.
   a_front_is_new : assert property (@(posedge clock) disable iff (reset)
      accept |=> (valid_vec[0] && entry[1] == $past(req_chan.version)))
      else $error("front entry is not the last accepted version");

   // A header with no predecessor yields an all-zero result.
   a_first_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.prev_hash_compressed) |->
      (rsp_chan.ver_position == '0 && !rsp_chan.time_compressed &&
       !rsp_chan.bits_compressed && rsp_chan.time_delta == '0))
      else $error("first-in-chain result carries nonzero fields");

endmodule
